/* sv/dbdt_pkg.sv */
// Shared types, constants and the box union helper for the double-buffer damage tracker.
package dbdt_pkg;

  localparam int unsigned SCR_W = 14;
  localparam int unsigned AREA_POS_W = 13;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [SCR_W-1:0] SCREEN_MAX = 14'd8192;
  localparam logic [SCR_W-1:0] SCREEN_W_RST = 14'd1920;
  localparam logic [SCR_W-1:0] SCREEN_H_RST = 14'd1080;

  localparam int unsigned COLUMN_ALIGN_DEF = 4;
  localparam int unsigned BAND_ROWS_DEF = 8;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_e;

  // Box as corner pair; vld low means empty.
  typedef struct packed {
    logic             vld;
    logic [SCR_W-1:0] x0;
    logic [SCR_W-1:0] y0;
    logic [SCR_W-1:0] x1;
    logic [SCR_W-1:0] y1;
  } box_t;

  localparam box_t BOX_EMPTY = '0;

  typedef struct packed {
    logic               buffer_select;
    logic               whole_screen;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic               last_rect;
  } in_item_t;

  // Bounding box of two boxes, empty operands ignored.
  function automatic box_t box_union(box_t a, box_t b);
    box_t r;
    r = a;
    if (!b.vld) begin
      r = a;
    end else if (!a.vld) begin
      r = b;
    end else begin
      r.vld = 1'b1;
      r.x0  = (a.x0 < b.x0) ? a.x0 : b.x0;
      r.y0  = (a.y0 < b.y0) ? a.y0 : b.y0;
      r.x1  = (a.x1 > b.x1) ? a.x1 : b.x1;
      r.y1  = (a.y1 > b.y1) ? a.y1 : b.y1;
    end
    return r;
  endfunction

endpackage

/* sv/dbdt_in_if.sv */
// Request channel carrying one damage rectangle item.
interface dbdt_in_if;
  logic               valid;
  logic               ready;
  logic               buffer_select;
  logic               whole_screen;
  logic signed [15:0] rect_left;
  logic signed [15:0] rect_top;
  logic signed [15:0] rect_width;
  logic signed [15:0] rect_height;
  logic signed [15:0] shift_x;
  logic signed [15:0] shift_y;
  logic               last_rect;

  modport source (
    output valid, buffer_select, whole_screen, rect_left, rect_top, rect_width,
           rect_height, shift_x, shift_y, last_rect,
    input  ready
  );
  modport sink (
    input  valid, buffer_select, whole_screen, rect_left, rect_top, rect_width,
           rect_height, shift_x, shift_y, last_rect,
    output ready
  );
endinterface

/* sv/dbdt_out_if.sv */
// Result channel carrying one refresh region.
interface dbdt_out_if;
  logic        valid;
  logic        ready;
  logic        copy_needed;
  logic [12:0] area_left;
  logic [12:0] area_top;
  logic [13:0] area_width;
  logic [13:0] area_height;

  modport source (
    output valid, copy_needed, area_left, area_top, area_width, area_height,
    input  ready
  );
  modport sink (
    input  valid, copy_needed, area_left, area_top, area_width, area_height,
    output ready
  );
endinterface

/* sv/dbdt_align.sv */
// One axis of region alignment: snap start down and end up to ALIGN, clamp to limit.
module dbdt_align #(
  parameter int unsigned ALIGN = dbdt_pkg::COLUMN_ALIGN_DEF
) (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [dbdt_pkg::SCR_W-1:0] lo_i,
  input  logic [dbdt_pkg::SCR_W-1:0] hi_i,
  input  logic [dbdt_pkg::SCR_W-1:0] limit_i,
  output logic [dbdt_pkg::SCR_W-1:0] pos_o,
  output logic [dbdt_pkg::SCR_W-1:0] len_o
);
  import dbdt_pkg::*;

  // floor(n / ALIGN) as (n * MULT) >> SHIFT, exact for n < 2**SCR_W
  localparam int unsigned SHIFT  = SCR_W + $clog2(ALIGN);
  localparam int unsigned MULT   = ((1 << SHIFT) + ALIGN - 1) / ALIGN;
  localparam int unsigned MULT_W = SCR_W + 2;
  localparam int unsigned PROD_W = SCR_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT_L = MULT_W'(MULT);
  localparam logic [SCR_W-1:0] ALIGN_L = SCR_W'(ALIGN);

  logic [SCR_W-1:0]  hi_up;
  logic [PROD_W-1:0] prod_lo, prod_hi;
  logic [SCR_W-1:0]  q_lo_d, q_hi_d, q_lo_q, q_hi_q;
  logic [SCR_W-1:0]  start, stop, span, room;

  assign hi_up   = hi_i + (ALIGN_L - 14'd1);
  assign prod_lo = PROD_W'(lo_i) * PROD_W'(MULT_L);
  assign prod_hi = PROD_W'(hi_up) * PROD_W'(MULT_L);
  assign q_lo_d  = SCR_W'(prod_lo >> SHIFT);
  assign q_hi_d  = SCR_W'(prod_hi >> SHIFT);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_lo_q <= q_lo_d;
      q_hi_q <= q_hi_d;
    end
  end

  always_comb begin
    start = q_lo_q * ALIGN_L;
    stop  = q_hi_q * ALIGN_L;
    span  = stop - start;
    room  = limit_i - start;
    if (start >= limit_i) begin
      len_o = '0;
    end else begin
      len_o = (span < room) ? span : room;
    end
    pos_o = start;
  end

endmodule

/* sv/double_buffer_damage_tracker_core.sv */
// Top level of the double-buffer damage tracker.
// Accepts one damage rectangle request per cycle unless a frame-ending one waits for room.
// A request that neither ends a frame (last_rect) nor covers the whole screen only grows
// the running damage box and gives no result; a frame-ending request gives exactly one
// refresh region through the state update, reciprocal divide and align-and-clamp into the
// result register, one result per cycle sustained while the sink keeps ready high. The
// per-request rate is set by the clip-and-union step, which reads and writes the damage,
// pending and full-mark state in the same cycle. Regions are snapped to COLUMN_ALIGN-pixel
// columns and BAND_ROWS-row bands and clamped to the screen; an empty region comes out with
// copy_needed low and all area fields zero. screen_width (address 0) and screen_height
// (address 4) saturate at 8192 and should be written only while no request is in flight.
module double_buffer_damage_tracker_core #(
  parameter int unsigned COLUMN_ALIGN = dbdt_pkg::COLUMN_ALIGN_DEF,
  parameter int unsigned BAND_ROWS    = dbdt_pkg::BAND_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dbdt_in_if.sink                         in_i,
  dbdt_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dbdt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dbdt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dbdt_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dbdt_pkg::*;

  // ---------------- configuration ----------------
  logic [SCR_W-1:0] scr_w_q, scr_h_q, wval;
  reg_idx_e         widx;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[2]);
  assign wval   = (pwdata[SCR_W-1:0] > SCREEN_MAX) ? SCREEN_MAX : pwdata[SCR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SCREEN_W_RST;
      scr_h_q <= SCREEN_H_RST;
    end else if (cfg_wr) begin
      unique case (widx)
        REG_SCREEN_WIDTH:  scr_w_q <= wval;
        REG_SCREEN_HEIGHT: scr_h_q <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(scr_w_q);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(scr_h_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic     s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic     s1_end, s1_go, s2_rdy, s3_rdy, out_rdy;
  in_item_t item_q;

  assign out_rdy  = !out_vld_q || out_o.ready;
  assign s3_rdy   = !s3_vld_q || out_rdy;
  assign s2_rdy   = !s2_vld_q || s3_rdy;
  assign s1_end   = item_q.whole_screen || item_q.last_rect;
  // non-ending requests retire here and never need room downstream
  assign s1_go    = s1_vld_q && (!s1_end || s2_rdy);
  assign in_i.ready = !s1_vld_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_vld_q  <= in_i.valid;
      if (s2_rdy)     s2_vld_q  <= s1_go && s1_end;
      if (s3_rdy)     s3_vld_q  <= s2_vld_q;
      if (out_rdy)    out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.buffer_select <= in_i.buffer_select;
      item_q.whole_screen  <= in_i.whole_screen;
      item_q.rect_left     <= in_i.rect_left;
      item_q.rect_top      <= in_i.rect_top;
      item_q.rect_width    <= in_i.rect_width;
      item_q.rect_height   <= in_i.rect_height;
      item_q.shift_x       <= in_i.shift_x;
      item_q.shift_y       <= in_i.shift_y;
      item_q.last_rect     <= in_i.last_rect;
    end
  end

  // ---------------- clip, union and buffer state ----------------
  logic signed [16:0] rx, ry;
  logic signed [17:0] rx_end, ry_end, cx0, cy0, cx1, cy1, sw_s, sh_s;
  box_t               clip_box, screen, acc, damage, area;
  box_t               dmg_q, dmg_d;
  box_t               pend_q [2];
  box_t               pend_d [2];
  logic [1:0]         full_q, full_d;
  logic               sel;

  assign sel  = item_q.buffer_select;
  assign sw_s = $signed({4'b0, scr_w_q});
  assign sh_s = $signed({4'b0, scr_h_q});

  always_comb begin
    rx     = 17'(item_q.rect_left) + 17'(item_q.shift_x);
    ry     = 17'(item_q.rect_top) + 17'(item_q.shift_y);
    rx_end = 18'(rx) + 18'(item_q.rect_width);
    ry_end = 18'(ry) + 18'(item_q.rect_height);
    cx0    = (rx < 0) ? 18'sd0 : 18'(rx);
    cy0    = (ry < 0) ? 18'sd0 : 18'(ry);
    cx1    = (rx_end < sw_s) ? rx_end : sw_s;
    cy1    = (ry_end < sh_s) ? ry_end : sh_s;
    // a non-positive size or an empty screen already fails these compares
    clip_box.vld = (cx1 > cx0) && (cy1 > cy0);
    clip_box.x0  = cx0[SCR_W-1:0];
    clip_box.y0  = cy0[SCR_W-1:0];
    clip_box.x1  = cx1[SCR_W-1:0];
    clip_box.y1  = cy1[SCR_W-1:0];

    screen.vld = (scr_w_q != '0) && (scr_h_q != '0);
    screen.x0  = '0;
    screen.y0  = '0;
    screen.x1  = scr_w_q;
    screen.y1  = scr_h_q;

    acc    = box_union(dmg_q, clip_box);
    damage = item_q.whole_screen ? screen : acc;
    area   = full_q[sel] ? screen : box_union(pend_q[sel], damage);

    dmg_d  = dmg_q;
    pend_d = pend_q;
    full_d = full_q;
    if (s1_go) begin
      if (s1_end) begin
        dmg_d        = BOX_EMPTY;
        full_d[sel]  = 1'b0;
        pend_d[sel]  = BOX_EMPTY;
        pend_d[!sel] = box_union(pend_q[!sel], damage);
      end else begin
        dmg_d = acc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmg_q     <= BOX_EMPTY;
      pend_q[0] <= BOX_EMPTY;
      pend_q[1] <= BOX_EMPTY;
      full_q    <= 2'b11;
    end else begin
      dmg_q     <= dmg_d;
      pend_q[0] <= pend_d[0];
      pend_q[1] <= pend_d[1];
      full_q    <= full_d;
    end
  end

  // ---------------- alignment ----------------
  box_t             area_q;
  logic             area_vld_q;
  logic [SCR_W-1:0] xpos, xlen, ypos, ylen;
  logic             copy;

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_go && s1_end) area_q <= area;
    if (s3_rdy && s2_vld_q)        area_vld_q <= area_q.vld;
  end

  dbdt_align #(.ALIGN(COLUMN_ALIGN)) u_align_x (
    .clk_i   (clk_i),
    .load_i  (s3_rdy && s2_vld_q),
    .lo_i    (area_q.x0),
    .hi_i    (area_q.x1),
    .limit_i (scr_w_q),
    .pos_o   (xpos),
    .len_o   (xlen)
  );

  dbdt_align #(.ALIGN(BAND_ROWS)) u_align_y (
    .clk_i   (clk_i),
    .load_i  (s3_rdy && s2_vld_q),
    .lo_i    (area_q.y0),
    .hi_i    (area_q.y1),
    .limit_i (scr_h_q),
    .pos_o   (ypos),
    .len_o   (ylen)
  );

  assign copy = area_vld_q && (xlen != '0) && (ylen != '0);

  // ---------------- result register ----------------
  logic                  copy_q;
  logic [AREA_POS_W-1:0] left_q, top_q;
  logic [SCR_W-1:0]      width_q, height_q;

  always_ff @(posedge clk_i) begin
    if (out_rdy && s3_vld_q) begin
      copy_q   <= copy;
      left_q   <= copy ? xpos[AREA_POS_W-1:0] : '0;
      top_q    <= copy ? ypos[AREA_POS_W-1:0] : '0;
      width_q  <= copy ? xlen : '0;
      height_q <= copy ? ylen : '0;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.copy_needed = copy_q;
  assign out_o.area_left   = left_q;
  assign out_o.area_top    = top_q;
  assign out_o.area_width  = width_q;
  assign out_o.area_height = height_q;

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.copy_needed |->
      out_o.area_left == '0 && out_o.area_top == '0 &&
      out_o.area_width == '0 && out_o.area_height == '0)
    else $error("empty region with nonzero area fields");

  a_screen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scr_w_q <= SCREEN_MAX && scr_h_q <= SCREEN_MAX)
    else $error("screen register above maximum");

  a_frame_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_end |=> !full_q[$past(sel)] && !pend_q[$past(sel)].vld && !dmg_q.vld)
    else $error("frame end did not clear buffer state");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_vld_q) |-> $past(s1_go && s1_end))
    else $error("region stage loaded without a frame-ending request");
`endif

endmodule
